>>> sv/lppd_pkg.sv
// lppd_pkg: shared types, register codes and helpers for the line position pid drive
// no dependencies; used by lppd_csr, lppd_law and line_position_pid_drive
package lppd_pkg;

   // widths of the control law datapath
   localparam int unsigned GAIN_W  = 12;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned SPEED_W = 8;
   localparam int unsigned SUM_W   = 24;
   localparam int unsigned ACC_W   = 40;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 12;

   // drive saturation limit and accumulator limits
   localparam logic signed [ACC_W-1:0] DRIVE_LIMIT = 40'sd100;
   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_POS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_BND = 3'd4;

   // reset values of the configuration registers
   localparam logic [GAIN_W-1:0] GAIN_P_RST     = 12'd218;
   localparam logic [GAIN_W-1:0] GAIN_D_RST     = 12'd51;
   localparam logic [GAIN_W-1:0] GAIN_I_RST     = 12'd0;
   localparam logic [POS_W-1:0]  TARGET_POS_RST = 7'd65;
   localparam logic [POS_W-1:0]  SETTLE_BND_RST = 7'd8;

   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [SPEED_W-1:0] base_speed;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_drive;
      logic signed [SPEED_W-1:0] right_drive;
      logic signed [SPEED_W-1:0] error_value;
      logic                      settled;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] gain_i;
      logic [POS_W-1:0]  target_position;
      logic [POS_W-1:0]  settle_band;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]        previous_position;
      logic signed [SUM_W-1:0] error_sum;
   } state_type;

   // divide a Q.8 drive by 256 truncating toward zero, then clamp to +/-100
   function automatic logic signed [SPEED_W-1:0] clip_drive(
      input logic signed [ACC_W-1:0] scaled
   );
      logic signed [ACC_W-1:0] quot;
      logic signed [ACC_W-1:0] res;
      if (scaled < 0) begin
         quot = (scaled + 40'sd255) >>> 8;
      end else begin
         quot = scaled >>> 8;
      end
      if (quot > DRIVE_LIMIT) begin
         res = DRIVE_LIMIT;
      end else if (quot < -DRIVE_LIMIT) begin
         res = -DRIVE_LIMIT;
      end else begin
         res = quot;
      end
      return res[SPEED_W-1:0];
   endfunction

endpackage

>>> sv/line_position_pid_drive.sv
// line_position_pid_drive: top level of the line position pid motor drive
// depends on lppd_pkg, lppd_csr and lppd_law
//
// Usage:
//   req_valid/req_stall/req_data carry one position sample and base speed;
//   a transfer happens at a rising edge with valid high and stall low.
//   rsp_valid/rsp_stall/rsp_data return left and right drive, the error and
//   the settled flag, one result per sample, in order.
//   csr_wen/csr_index/csr_wdata write the gains, target and band; write them
//   only while no sample is in flight.
// Path: a sample taken into the input register passes once through the three
//   multipliers of the control law into the result register that drives rsp_data.
// Throughput: one sample per cycle while rsp_stall is low.
// Stall: while rsp_stall holds a result, one more sample may wait in the
//   input register; after that req_stall rises until the result is taken.
// Reset: synchronous; empties both registers, clears the stored position and
//   error accumulator and returns the configuration to its defaults.
module line_position_pid_drive (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lppd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lppd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wen,
   input  logic [lppd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lppd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lppd_pkg::cfg_type   cfg;
   lppd_pkg::req_type   sample_ff;
   logic                sample_valid_ff;
   logic                sample_valid_in;
   lppd_pkg::state_type state_ff;
   lppd_pkg::state_type state_in;
   lppd_pkg::rsp_type   result;
   lppd_pkg::rsp_type   rsp_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                req_take;
   logic                advance;

   lppd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lppd_law u_law (
      .sample    (sample_ff),
      .state_cur (state_ff),
      .cfg       (cfg),
      .result    (result),
      .state_nxt (state_in)
   );

   // handshake: the sample moves on when the result register is free or its result is taken
   assign advance   = sample_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = sample_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      sample_valid_in = sample_valid_ff;
      if (req_take) begin
         sample_valid_in = 1'b1;
      end else if (advance) begin
         sample_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= '0;
      end else begin
         sample_valid_ff <= sample_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a held result blocks the input once the input register is occupied
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && sample_valid_ff) |-> req_stall)
      else $error("input taken while both registers are full");

   // a sample that moves on always shows up as a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced sample did not produce a result");

   // loop state changes only when a sample is consumed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("loop state changed without a sample");
`endif

endmodule

>>> sv/lppd_csr.sv
// lppd_csr: configuration registers (gains, target position, settle band)
// depends on lppd_pkg for the register codes, reset values and cfg_type
module lppd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [lppd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lppd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lppd_pkg::cfg_type                   cfg
);

   lppd_pkg::cfg_type cfg_ff;
   lppd_pkg::cfg_type cfg_in;

   // register decode, values masked to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            lppd_pkg::CSR_GAIN_P:     cfg_in.gain_p = csr_wdata;
            lppd_pkg::CSR_GAIN_D:     cfg_in.gain_d = csr_wdata;
            lppd_pkg::CSR_GAIN_I:     cfg_in.gain_i = csr_wdata;
            lppd_pkg::CSR_TARGET_POS: cfg_in.target_position = csr_wdata[lppd_pkg::POS_W-1:0];
            lppd_pkg::CSR_SETTLE_BND: cfg_in.settle_band = csr_wdata[lppd_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= lppd_pkg::GAIN_P_RST;
         cfg_ff.gain_d          <= lppd_pkg::GAIN_D_RST;
         cfg_ff.gain_i          <= lppd_pkg::GAIN_I_RST;
         cfg_ff.target_position <= lppd_pkg::TARGET_POS_RST;
         cfg_ff.settle_band     <= lppd_pkg::SETTLE_BND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/lppd_law.sv
// lppd_law: combinational pid law with derivative on the measurement
// depends on lppd_pkg for the payload, state and configuration types
module lppd_law (
   input  lppd_pkg::req_type   sample,
   input  lppd_pkg::state_type state_cur,
   input  lppd_pkg::cfg_type   cfg,
   output lppd_pkg::rsp_type   result,
   output lppd_pkg::state_type state_nxt
);

   logic signed [7:0]                  err;
   logic signed [7:0]                  delta;
   logic [7:0]                         mag;
   logic signed [20:0]                 p_term;
   logic signed [20:0]                 d_term;
   logic signed [36:0]                 i_term;
   logic signed [lppd_pkg::ACC_W-1:0]  acc;
   logic signed [lppd_pkg::ACC_W-1:0]  base_scaled;
   logic signed [lppd_pkg::SUM_W:0]    sum_wide;

   // error and position change
   assign err   = $signed({1'b0, sample.position}) - $signed({1'b0, cfg.target_position});
   assign delta = $signed({1'b0, sample.position})
                - $signed({1'b0, state_cur.previous_position});
   assign mag   = err[7] ? 8'(-err) : 8'(err);

   // three gain products, unsigned gains widened to signed
   assign p_term = $signed({1'b0, cfg.gain_p}) * err;
   assign d_term = $signed({1'b0, cfg.gain_d}) * delta;
   assign i_term = $signed({1'b0, cfg.gain_i}) * state_cur.error_sum;

   // drive scaled by 256, and the base speed at the same scale
   assign acc = lppd_pkg::ACC_W'(p_term) + lppd_pkg::ACC_W'(d_term)
              + lppd_pkg::ACC_W'(i_term);
   assign base_scaled = lppd_pkg::ACC_W'(sample.base_speed) <<< 8;

   always_comb begin
      result.left_drive  = lppd_pkg::clip_drive(base_scaled + acc);
      result.right_drive = lppd_pkg::clip_drive(base_scaled - acc);
      result.error_value = err;
      result.settled     = (mag < {1'b0, cfg.settle_band});
   end

   // saturating error accumulator, position kept for the next change
   assign sum_wide = (lppd_pkg::SUM_W+1)'(state_cur.error_sum) + (lppd_pkg::SUM_W+1)'(err);

   always_comb begin
      state_nxt.previous_position = sample.position;
      if (sum_wide > (lppd_pkg::SUM_W+1)'(lppd_pkg::SUM_MAX)) begin
         state_nxt.error_sum = lppd_pkg::SUM_MAX;
      end else if (sum_wide < (lppd_pkg::SUM_W+1)'(lppd_pkg::SUM_MIN)) begin
         state_nxt.error_sum = lppd_pkg::SUM_MIN;
      end else begin
         state_nxt.error_sum = sum_wide[lppd_pkg::SUM_W-1:0];
      end
   end

endmodule
